>>> rtl/tlnef_pkg.sv
// ----------------------------------------------------------------------------
// tlnef_pkg
// Shared types and constants of the line numbering and escape filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tlnef_pkg;

  // line counter width and its hard ceiling
  localparam int LINE_W = 20;
  localparam longint unsigned LINE_MAX = 64'hFFFFF;

  // configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_NONBLANK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_ALL       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = CFG_IDX_W'(5);

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // feature switches
  typedef struct packed {
    logic number_nonblank;
    logic number_all;
    logic squeeze_blank;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // one classified item: optional number prefix plus up to four tail bytes
  typedef struct packed {
    logic            has_num;
    logic [1:0]      tail_last;
    logic [3:0][7:0] tail;
  } desc_t;

endpackage

`default_nettype wire

>>> rtl/text_line_number_escape_filter_core.sv
// ----------------------------------------------------------------------------
// text_line_number_escape_filter_core
// Line numbering, blank squeezing and caret / M- escaping of a byte stream.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | in_byte
// out     | output    | out_valid/out_stall| out_byte, last_of_run
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The back end emits one output byte per cycle while the queue holds an item
// and out_stall is low. An item has 1 output byte for a plain byte, up to 4 for an escape,
// plus NUMBER_DIGITS + 1 when a line number is printed.
// A squeezed newline produces no transaction on the output.
// A two-entry queue sits between the classifier and the expander.
// rst is synchronous; all state is ready as soon as it drops.
// in_stall rises only when the queue is full; out_stall holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_number_escape_filter_core #(
  // digits of the printed line number, 1 to 9
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_byte,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [7:0]                            out_byte,
  output logic                                  last_of_run,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tlnef_pkg::*;

  localparam int DigW = NUMBER_DIGITS * 4;
  localparam int DescW = $bits(desc_t);
  localparam int QW = DescW + DigW;

  desc_t            f_desc;
  logic [DigW-1:0]  f_digits;
  logic             f_push;
  logic             q_full;
  logic             q_pop;
  logic             q_head_valid;
  logic [QW-1:0]    q_head;
  desc_t            b_desc;
  logic [DigW-1:0]  b_digits;

  // classifier and line state
  tlnef_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (f_push),
    .desc      (f_desc),
    .digits    (f_digits)
  );

  // item queue
  tlnef_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (f_push),
    .push_data  ({f_digits, f_desc}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head)
  );

  assign b_desc   = q_head[DescW-1:0];
  assign b_digits = q_head[QW-1:DescW];

  // expander and output register
  tlnef_back #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head_desc   (b_desc),
    .head_digits (b_digits),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

>>> rtl/tlnef_front.sv
// ----------------------------------------------------------------------------
// tlnef_front
// Accepts input bytes, tracks line state and classifies each byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnef_front #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                             q_full,
  output logic                                  push,
  output tlnef_pkg::desc_t                      desc,
  output logic [NUMBER_DIGITS*4-1:0]            digits
);
  import tlnef_pkg::*;

  localparam longint unsigned LimitWide = (64'd10 ** NUMBER_DIGITS) - 64'd1;
  localparam logic [LINE_W-1:0] LineLimit =
    (LimitWide > LINE_MAX) ? LINE_W'(LINE_MAX) : LINE_W'(LimitWide);

  cfg_t              cfg;
  logic [LINE_W-1:0] line_bin;
  logic [3:0]        bcd [NUMBER_DIGITS];
  logic [3:0]        bcd_next [NUMBER_DIGITS];
  logic [1:0]        newline_run;
  logic [1:0]        newline_run_next;
  logic              at_line_start;
  logic              accept;
  logic              is_nl;
  logic              squeezed;
  logic              want_num;
  logic              carry;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign is_nl     = (in_byte == CH_NL);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUMBER_NONBLANK:  cfg.number_nonblank  <= cfg_data[0];
        REG_NUMBER_ALL:       cfg.number_all       <= cfg_data[0];
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // newline run and squeeze decision
  always_comb begin
    if (is_nl) begin
      newline_run_next = (newline_run == 2'd3) ? 2'd3 : newline_run + 2'd1;
    end else begin
      newline_run_next = 2'd0;
    end
    squeezed = cfg.squeeze_blank && (newline_run_next == 2'd3);
    if (cfg.number_nonblank) begin
      want_num = at_line_start && !is_nl;
    end else begin
      want_num = at_line_start && cfg.number_all;
    end
  end

  assign push = accept && !squeezed;

  // decimal increment of the line number
  always_comb begin
    carry = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      bcd_next[i] = bcd[i];
      if (carry) begin
        if (bcd[i] == 4'd9) begin
          bcd_next[i] = 4'd0;
        end else begin
          bcd_next[i] = bcd[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      newline_run   <= 2'd1;
      at_line_start <= 1'b1;
      line_bin      <= LINE_W'(1);
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
        bcd[i] <= (i == 0) ? 4'd1 : 4'd0;
      end
    end else if (accept) begin
      newline_run   <= newline_run_next;
      at_line_start <= is_nl;
      if (!squeezed && want_num && (line_bin < LineLimit)) begin
        line_bin <= line_bin + LINE_W'(1);
        bcd      <= bcd_next;
      end
    end
  end

  // digits travel least significant first
  always_comb begin
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      digits[i*4 +: 4] = bcd[i];
    end
  end

  // classify the byte into its tail bytes
  always_comb begin
    desc         = '0;
    desc.has_num = want_num;
    if (in_byte == CH_TAB && cfg.show_tabs) begin
      desc.tail[0]   = CH_CARET;
      desc.tail[1]   = CH_I;
      desc.tail_last = 2'd1;
    end else if (is_nl && cfg.show_ends) begin
      desc.tail[0]   = CH_DOLLAR;
      desc.tail[1]   = CH_NL;
      desc.tail_last = 2'd1;
    end else if (cfg.show_nonprinting && !(in_byte == CH_TAB || is_nl ||
                 (in_byte >= CH_SPACE && in_byte < CH_DEL))) begin
      if (in_byte == CH_DEL) begin
        desc.tail[0]   = CH_CARET;
        desc.tail[1]   = CH_QMARK;
        desc.tail_last = 2'd1;
      end else if (in_byte >= 8'd160) begin
        desc.tail[0] = CH_M;
        desc.tail[1] = CH_DASH;
        if (in_byte != 8'hFF) begin
          desc.tail[2]   = in_byte - 8'd128;
          desc.tail_last = 2'd2;
        end else begin
          desc.tail[2]   = CH_CARET;
          desc.tail[3]   = CH_QMARK;
          desc.tail_last = 2'd3;
        end
      end else if (in_byte >= 8'd128) begin
        desc.tail[0]   = CH_M;
        desc.tail[1]   = CH_DASH;
        desc.tail[2]   = CH_CARET;
        desc.tail[3]   = in_byte - 8'd64;
        desc.tail_last = 2'd3;
      end else begin
        desc.tail[0]   = CH_CARET;
        desc.tail[1]   = in_byte + 8'd64;
        desc.tail_last = 2'd1;
      end
    end else begin
      desc.tail[0]   = in_byte;
      desc.tail_last = 2'd0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlnef_queue.sv
// ----------------------------------------------------------------------------
// tlnef_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnef_queue #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);
  import tlnef_pkg::*;

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rptr + PtrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlnef_back.sv
// ----------------------------------------------------------------------------
// tlnef_back
// Expands the head item of the queue into output bytes, one per cycle while not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnef_back #(
  parameter int NUMBER_DIGITS = 6
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       head_valid,
  input  tlnef_pkg::desc_t                head_desc,
  input  wire logic [NUMBER_DIGITS*4-1:0] head_digits,
  output logic                            pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run
);
  import tlnef_pkg::*;

  localparam int CntW =
    ($clog2(NUMBER_DIGITS + 1) > 2) ? $clog2(NUMBER_DIGITS + 1) : 2;

  typedef enum logic [1:0] {
    PH_NUM  = 2'b01,
    PH_TAIL = 2'b10
  } phase_t;

  phase_t          phase;
  phase_t          phase_next;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] cnt_next;
  logic            seen_nz;
  logic            seen_nz_next;
  logic            load_ok;
  logic            fire;
  logic            eff_tail;
  logic [3:0]      dig;
  logic            show_dig;
  logic [7:0]      byte_sel;
  logic            last_sel;

  assign load_ok  = !out_valid || !out_stall;
  assign fire     = head_valid && load_ok;
  assign eff_tail = (phase == PH_TAIL) || !head_desc.has_num;

  // pick the digit for the current position, most significant first
  always_comb begin
    dig = 4'd0;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (cnt == CntW'(NUMBER_DIGITS - 1 - i)) begin
        dig = head_digits[i*4 +: 4];
      end
    end
    show_dig = (dig != 4'd0) || seen_nz || (cnt == CntW'(NUMBER_DIGITS - 1));
  end

  // byte selection and sequencing
  always_comb begin
    byte_sel     = 8'd0;
    last_sel     = 1'b0;
    pop          = 1'b0;
    phase_next   = phase;
    cnt_next     = cnt;
    seen_nz_next = seen_nz;
    if (!eff_tail) begin
      if (cnt == CntW'(NUMBER_DIGITS)) begin
        byte_sel   = CH_TAB;
        cnt_next   = '0;
        phase_next = PH_TAIL;
      end else begin
        byte_sel     = show_dig ? (CH_ZERO + {4'd0, dig}) : CH_SPACE;
        seen_nz_next = seen_nz || show_dig;
        cnt_next     = cnt + CntW'(1);
      end
    end else begin
      byte_sel = head_desc.tail[cnt[1:0]];
      last_sel = (cnt[1:0] == head_desc.tail_last);
      if (last_sel) begin
        pop          = fire;
        cnt_next     = '0;
        phase_next   = PH_NUM;
        seen_nz_next = 1'b0;
      end else begin
        cnt_next   = cnt + CntW'(1);
        phase_next = PH_TAIL;
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_NUM;
      cnt     <= '0;
      seen_nz <= 1'b0;
    end else if (fire) begin
      phase   <= phase_next;
      cnt     <= cnt_next;
      seen_nz <= seen_nz_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte    <= byte_sel;
      last_of_run <= last_sel;
    end
  end

endmodule

`default_nettype wire

>>> rtl/tlnef_checker.sv
// ----------------------------------------------------------------------------
// tlnef_checker
// Port level checks of the filter core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlnef_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic [7:0]                       in_byte,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic [7:0]                       out_byte,
  input wire logic                             last_of_run,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a held output transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
    else $error("output payload changed while stalled");

  // the input only backs up while output is pending
  a_stall_needs_out: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output pending");

  // the bytes of one run follow without gaps
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_of_run |=> out_valid)
    else $error("gap inside an output run");

  // reset leaves both channels quiet
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("channels busy right after reset");

endmodule

bind text_line_number_escape_filter_core tlnef_checker u_checker (.*);

`default_nettype wire
